// ===== sv/sfcv_pkg.sv =====
`timescale 1ns / 1ps

package sfcv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VEC_N     = 3;
    localparam int VEC_W     = 32;
    localparam int OPND_W    = VEC_W + 1;
    localparam int PROD_W    = 2 * VEC_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int COEF_W    = 31;
    localparam int DT_W      = 17;
    localparam int CFG_IDX_W = 2;
    localparam int ROOT_W    = VEC_W;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int DIVD_W    = VEC_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic signed [OPND_W-1:0] t_opnd;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        logic mul_en;
        logic div_start;
    } t_lane_cmd;

    function automatic t_acc ext_vec(input t_vec v);
        return t_acc'(v);
    endfunction

    function automatic t_acc ext_prod(input t_prod p);
        return t_acc'(p);
    endfunction

    function automatic t_opnd opnd_of(input t_vec v);
        return t_opnd'(v);
    endfunction

    function automatic t_vec sat_vec(input t_acc x);
        logic [ACC_W-VEC_W:0] top;
        top = x[ACC_W-1:VEC_W-1];
        if (top == '0 || top == '1) begin
            return x[VEC_W-1:0];
        end
        if (x[ACC_W-1]) begin
            return {1'b1, {(VEC_W-1){1'b0}}};
        end
        return {1'b0, {(VEC_W-1){1'b1}}};
    endfunction

endpackage

// ===== sv/sfcv_item_if.sv =====
`timescale 1ns / 1ps

interface sfcv_item_if;
    logic valid;
    logic ready;
    logic mode;
    logic signed [sfcv_pkg::VEC_W-1:0] target_x;
    logic signed [sfcv_pkg::VEC_W-1:0] target_y;
    logic signed [sfcv_pkg::VEC_W-1:0] target_z;
    logic signed [sfcv_pkg::VEC_W-1:0] heading_x;
    logic signed [sfcv_pkg::VEC_W-1:0] heading_y;
    logic signed [sfcv_pkg::VEC_W-1:0] heading_z;
    logic signed [sfcv_pkg::VEC_W-1:0] target_up_x;
    logic signed [sfcv_pkg::VEC_W-1:0] target_up_y;
    logic signed [sfcv_pkg::VEC_W-1:0] target_up_z;
    logic [sfcv_pkg::DT_W-1:0] delta_time;

    modport source (
        output valid, mode, target_x, target_y, target_z, heading_x, heading_y, heading_z,
               target_up_x, target_up_y, target_up_z, delta_time,
        input  ready
    );
    modport sink (
        input  valid, mode, target_x, target_y, target_z, heading_x, heading_y, heading_z,
               target_up_x, target_up_y, target_up_z, delta_time,
        output ready
    );
endinterface

// ===== sv/sfcv_result_if.sv =====
`timescale 1ns / 1ps

interface sfcv_result_if;
    logic valid;
    logic ready;
    logic signed [sfcv_pkg::VEC_W-1:0] right_x;
    logic signed [sfcv_pkg::VEC_W-1:0] right_y;
    logic signed [sfcv_pkg::VEC_W-1:0] right_z;
    logic signed [sfcv_pkg::VEC_W-1:0] right_offset;
    logic signed [sfcv_pkg::VEC_W-1:0] upward_x;
    logic signed [sfcv_pkg::VEC_W-1:0] upward_y;
    logic signed [sfcv_pkg::VEC_W-1:0] upward_z;
    logic signed [sfcv_pkg::VEC_W-1:0] upward_offset;
    logic signed [sfcv_pkg::VEC_W-1:0] back_x;
    logic signed [sfcv_pkg::VEC_W-1:0] back_y;
    logic signed [sfcv_pkg::VEC_W-1:0] back_z;
    logic signed [sfcv_pkg::VEC_W-1:0] back_offset;

    modport source (
        output valid, right_x, right_y, right_z, right_offset, upward_x, upward_y, upward_z,
               upward_offset, back_x, back_y, back_z, back_offset,
        input  ready
    );
    modport sink (
        input  valid, right_x, right_y, right_z, right_offset, upward_x, upward_y, upward_z,
               upward_offset, back_x, back_y, back_z, back_offset,
        output ready
    );
endinterface

// ===== sv/sfcv_cfg_if.sv =====
`timescale 1ns / 1ps

interface sfcv_cfg_if;
    logic valid;
    logic ready;
    logic [sfcv_pkg::CFG_IDX_W-1:0] index;
    logic [sfcv_pkg::VEC_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/sfcv_lane.sv =====
`timescale 1ns / 1ps

module sfcv_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sfcv_pkg::t_lane_cmd           i_cmd,
    input  sfcv_pkg::t_opnd               i_mul_a,
    input  sfcv_pkg::t_opnd               i_mul_b,
    output sfcv_pkg::t_prod               o_prod,
    input  sfcv_pkg::t_vec                i_num,
    input  logic [sfcv_pkg::ROOT_W-1:0]   i_len,
    output sfcv_pkg::t_vec                o_quo,
    output logic                          o_busy
);

    logic signed [2*sfcv_pkg::OPND_W-1:0] full_prod;
    sfcv_pkg::t_prod                      r_prod;
    logic [sfcv_pkg::VEC_W-1:0]           mag;
    logic [sfcv_pkg::DIVD_W-1:0]          r_rem;
    logic [sfcv_pkg::DIVD_W-1:0]          r_den;
    logic [sfcv_pkg::QUO_W-1:0]           r_q;
    logic                                 r_neg;
    logic                                 r_busy;
    logic [sfcv_pkg::DIV_CNT_W-1:0]       r_cnt;

    assign full_prod = i_mul_a * i_mul_b;
    assign mag = i_num[sfcv_pkg::VEC_W-1] ? sfcv_pkg::VEC_W'(-i_num) : i_num;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= full_prod[sfcv_pkg::PROD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_busy <= 1'b1;
            r_cnt  <= sfcv_pkg::DIV_CNT_W'(sfcv_pkg::QUO_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= {mag, {sfcv_pkg::FRAC_BITS{1'b0}}};
            r_den <= {i_len, {sfcv_pkg::FRAC_BITS{1'b0}}};
            r_neg <= i_num[sfcv_pkg::VEC_W-1];
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_rem >= r_den) begin
                r_rem <= r_rem - r_den;
                r_q   <= {r_q[sfcv_pkg::QUO_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[sfcv_pkg::QUO_W-2:0], 1'b0};
            end
            r_den <= r_den >> 1;
        end
    end

    assign o_prod = r_prod;
    assign o_quo  = r_neg ? -sfcv_pkg::t_vec'(r_q) : sfcv_pkg::t_vec'(r_q);
    assign o_busy = r_busy;

endmodule

// ===== sv/sfcv_isqrt.sv =====
`timescale 1ns / 1ps

module sfcv_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sfcv_pkg::RAD_W-1:0]    i_radicand,
    output logic                          o_busy,
    output logic [sfcv_pkg::ROOT_W-1:0]   o_root
);

    logic [sfcv_pkg::RAD_W-1:0]      r_n;
    logic [sfcv_pkg::RAD_W-1:0]      r_r;
    logic [sfcv_pkg::RAD_W-1:0]      r_bit;
    logic [sfcv_pkg::RAD_W:0]        trial;
    logic                            r_busy;
    logic [sfcv_pkg::ROOT_CNT_W-1:0] r_cnt;

    assign trial = {1'b0, r_r} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= sfcv_pkg::ROOT_CNT_W'(sfcv_pkg::ROOT_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_radicand;
            r_r   <= '0;
            r_bit <= sfcv_pkg::RAD_W'(1) << (sfcv_pkg::RAD_W - 2);
        end else if (r_busy) begin
            if ({1'b0, r_n} >= trial) begin
                r_n <= r_n - trial[sfcv_pkg::RAD_W-1:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_r[sfcv_pkg::ROOT_W-1:0];

endmodule

// ===== sv/spring_follow_camera_view.sv =====
`timescale 1ns / 1ps

// Spring follow camera with look-at view output. Each accepted item moves the camera one
// damped spring step toward the point behind and above the target (or snaps it there when
// mode is 0) and returns the upper three rows of the view matrix, all in signed Q16.16.
// Most of an item's time goes to the five vector normalizations, each of which uses the
// shared square-root unit and then the three lane dividers; the spring step, the cross
// products and the dot products run on the three lane multipliers. The next item is
// accepted as soon as the previous one has left the datapath, while its result may still
// wait in the output register.
module spring_follow_camera_view (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sfcv_item_if.sink            i_item,
    sfcv_result_if.source        o_result,
    sfcv_cfg_if.sink             i_cfg
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ID1  = 5'd1;
    localparam logic [4:0] S_ID2  = 5'd2;
    localparam logic [4:0] S_ID3  = 5'd3;
    localparam logic [4:0] S_SP1  = 5'd4;
    localparam logic [4:0] S_SP2  = 5'd5;
    localparam logic [4:0] S_SP3  = 5'd6;
    localparam logic [4:0] S_SP4  = 5'd7;
    localparam logic [4:0] S_SP5  = 5'd8;
    localparam logic [4:0] S_SP6  = 5'd9;
    localparam logic [4:0] S_SP7  = 5'd10;
    localparam logic [4:0] S_SP8  = 5'd11;
    localparam logic [4:0] S_DIFF = 5'd12;
    localparam logic [4:0] S_N1   = 5'd13;
    localparam logic [4:0] S_N2   = 5'd14;
    localparam logic [4:0] S_N3   = 5'd15;
    localparam logic [4:0] S_N4   = 5'd16;
    localparam logic [4:0] S_C1   = 5'd17;
    localparam logic [4:0] S_C2   = 5'd18;
    localparam logic [4:0] S_C3   = 5'd19;
    localparam logic [4:0] S_D1   = 5'd20;
    localparam logic [4:0] S_D2   = 5'd21;
    localparam logic [4:0] S_EMIT = 5'd22;

    localparam logic [2:0] PH_F    = 3'd0;
    localparam logic [2:0] PH_UP   = 3'd1;
    localparam logic [2:0] PH_LEFT = 3'd2;
    localparam logic [2:0] PH_CUP  = 3'd3;
    localparam logic [2:0] PH_S    = 3'd4;
    localparam logic [2:0] PH_U    = 3'd5;

    localparam logic [1:0] DOT_S = 2'd0;
    localparam logic [1:0] DOT_U = 2'd1;
    localparam logic [1:0] DOT_F = 2'd2;

    localparam logic [sfcv_pkg::CFG_IDX_W-1:0] REG_STIFF  = 2'd0;
    localparam logic [sfcv_pkg::CFG_IDX_W-1:0] REG_DAMP   = 2'd1;
    localparam logic [sfcv_pkg::CFG_IDX_W-1:0] REG_DIST   = 2'd2;
    localparam logic [sfcv_pkg::CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    logic [4:0]                   r_state;
    logic [2:0]                   r_phase;
    logic [1:0]                   r_dsel;
    logic                         r_zero;
    logic                         r_mode;
    logic [sfcv_pkg::DT_W-1:0]    r_dt;
    logic [sfcv_pkg::COEF_W-1:0]  r_stiff;
    logic [sfcv_pkg::COEF_W-1:0]  r_damp;
    sfcv_pkg::t_vec               r_dist;
    sfcv_pkg::t_vec               r_height;

    sfcv_pkg::t_vec r_tgt   [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_fwd   [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_up    [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_pos   [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_vel   [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_ideal [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_tmp   [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_vec   [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_f     [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_s     [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_u     [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_ca    [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_cb    [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_dot   [sfcv_pkg::VEC_N];
    sfcv_pkg::t_acc r_acc   [sfcv_pkg::VEC_N];

    logic           r_out_valid;
    sfcv_pkg::t_vec r_o_s   [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_o_u   [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_o_b   [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec r_o_off [sfcv_pkg::VEC_N];

    sfcv_pkg::t_lane_cmd           lane_cmd;
    sfcv_pkg::t_opnd               lane_a  [sfcv_pkg::VEC_N];
    sfcv_pkg::t_opnd               lane_b  [sfcv_pkg::VEC_N];
    sfcv_pkg::t_prod               lane_p  [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec                lane_q  [sfcv_pkg::VEC_N];
    sfcv_pkg::t_acc                p_sh    [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec                norm_q  [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec                dvec    [sfcv_pkg::VEC_N];
    sfcv_pkg::t_vec                cross_r [sfcv_pkg::VEC_N];
    logic [sfcv_pkg::VEC_N-1:0]    div_busy;
    sfcv_pkg::t_acc                sum_p;
    sfcv_pkg::t_acc                dot_v;
    logic                          sqrt_start;
    logic                          sqrt_busy;
    logic [sfcv_pkg::ROOT_W-1:0]   root;
    logic                          in_take;
    logic                          out_load;
    logic                          norm_done;

    assign in_take  = i_item.valid && i_item.ready;
    assign out_load = (r_state == S_EMIT) && (!r_out_valid || o_result.ready);
    assign norm_done = (r_state == S_N4) && (r_zero || div_busy == '0);

    assign lane_cmd.mul_en = (r_state == S_ID1) || (r_state == S_ID2) || (r_state == S_SP2) ||
                             (r_state == S_SP3) || (r_state == S_SP5) || (r_state == S_SP7) ||
                             (r_state == S_N1) || (r_state == S_C1) || (r_state == S_C2) ||
                             (r_state == S_D1);
    assign lane_cmd.div_start = (r_state == S_N3) && !sqrt_busy && (root != '0);
    assign sqrt_start = (r_state == S_N2);

    // The merging stage adds the three lane products for the square sums and the dot products.
    assign sum_p = sfcv_pkg::ext_prod(lane_p[0]) + sfcv_pkg::ext_prod(lane_p[1]) +
                   sfcv_pkg::ext_prod(lane_p[2]);
    assign dot_v = (r_dsel == DOT_F) ? sum_p : -sum_p;

    always_comb begin
        unique case (r_dsel)
            DOT_S:   dvec = r_s;
            DOT_U:   dvec = r_u;
            default: dvec = r_f;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < sfcv_pkg::VEC_N; gi++) begin : g_lane
            localparam int J = (gi + 1) % sfcv_pkg::VEC_N;
            localparam int K = (gi + 2) % sfcv_pkg::VEC_N;
            sfcv_pkg::t_acc cross_d;

            always_comb begin
                lane_a[gi] = '0;
                lane_b[gi] = '0;
                unique case (r_state)
                    S_ID1: begin
                        lane_a[gi] = sfcv_pkg::opnd_of(r_dist);
                        lane_b[gi] = sfcv_pkg::opnd_of(r_fwd[gi]);
                    end
                    S_ID2: begin
                        lane_a[gi] = sfcv_pkg::opnd_of(r_height);
                        lane_b[gi] = sfcv_pkg::opnd_of(r_up[gi]);
                    end
                    S_SP2: begin
                        lane_a[gi] = sfcv_pkg::t_opnd'(r_stiff);
                        lane_b[gi] = sfcv_pkg::opnd_of(r_tmp[gi]);
                    end
                    S_SP3: begin
                        lane_a[gi] = sfcv_pkg::t_opnd'(r_damp);
                        lane_b[gi] = sfcv_pkg::opnd_of(r_vel[gi]);
                    end
                    S_SP5: begin
                        lane_a[gi] = sfcv_pkg::t_opnd'(r_dt);
                        lane_b[gi] = sfcv_pkg::opnd_of(r_tmp[gi]);
                    end
                    S_SP7: begin
                        lane_a[gi] = sfcv_pkg::t_opnd'(r_dt);
                        lane_b[gi] = sfcv_pkg::opnd_of(r_vel[gi]);
                    end
                    S_N1: begin
                        lane_a[gi] = sfcv_pkg::opnd_of(r_vec[gi]);
                        lane_b[gi] = sfcv_pkg::opnd_of(r_vec[gi]);
                    end
                    S_C1: begin
                        lane_a[gi] = sfcv_pkg::opnd_of(r_ca[J]);
                        lane_b[gi] = sfcv_pkg::opnd_of(r_cb[K]);
                    end
                    S_C2: begin
                        lane_a[gi] = sfcv_pkg::opnd_of(r_ca[K]);
                        lane_b[gi] = sfcv_pkg::opnd_of(r_cb[J]);
                    end
                    S_D1: begin
                        lane_a[gi] = sfcv_pkg::opnd_of(dvec[gi]);
                        lane_b[gi] = sfcv_pkg::opnd_of(r_pos[gi]);
                    end
                    default: begin
                    end
                endcase
            end

            assign p_sh[gi]    = sfcv_pkg::ext_prod(lane_p[gi]) >>> sfcv_pkg::FRAC_BITS;
            assign norm_q[gi]  = r_zero ? '0 : lane_q[gi];
            assign cross_d     = (r_acc[gi] - sfcv_pkg::ext_prod(lane_p[gi])) >>>
                                 sfcv_pkg::FRAC_BITS;
            assign cross_r[gi] = cross_d[sfcv_pkg::VEC_W-1:0];

            sfcv_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (lane_cmd),
                .i_mul_a (lane_a[gi]),
                .i_mul_b (lane_b[gi]),
                .o_prod  (lane_p[gi]),
                .i_num   (r_vec[gi]),
                .i_len   (root),
                .o_quo   (lane_q[gi]),
                .o_busy  (div_busy[gi])
            );
        end
    endgenerate

    sfcv_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (sum_p[sfcv_pkg::RAD_W-1:0]),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff  <= sfcv_pkg::COEF_W'(655360);
            r_damp   <= sfcv_pkg::COEF_W'(414485);
            r_dist   <= sfcv_pkg::VEC_W'(327680);
            r_height <= sfcv_pkg::VEC_W'(131072);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_STIFF:  r_stiff  <= i_cfg.data[sfcv_pkg::COEF_W-1:0];
                REG_DAMP:   r_damp   <= i_cfg.data[sfcv_pkg::COEF_W-1:0];
                REG_DIST:   r_dist   <= i_cfg.data;
                REG_HEIGHT: r_height <= i_cfg.data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_F;
            r_dsel  <= DOT_S;
            r_zero  <= 1'b0;
            for (int i = 0; i < sfcv_pkg::VEC_N; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_mode   <= i_item.mode;
                        r_dt     <= i_item.delta_time;
                        r_tgt[0] <= i_item.target_x;
                        r_tgt[1] <= i_item.target_y;
                        r_tgt[2] <= i_item.target_z;
                        r_fwd[0] <= i_item.heading_x;
                        r_fwd[1] <= i_item.heading_y;
                        r_fwd[2] <= i_item.heading_z;
                        r_up[0]  <= i_item.target_up_x;
                        r_up[1]  <= i_item.target_up_y;
                        r_up[2]  <= i_item.target_up_z;
                        r_state  <= S_ID1;
                    end
                end
                S_ID1: r_state <= S_ID2;
                S_ID2: begin
                    for (int i = 0; i < sfcv_pkg::VEC_N; i++) begin
                        r_acc[i] <= sfcv_pkg::ext_vec(r_tgt[i]) - p_sh[i];
                    end
                    r_state <= S_ID3;
                end
                S_ID3: begin
                    for (int i = 0; i < sfcv_pkg::VEC_N; i++) begin
                        r_ideal[i] <= sfcv_pkg::sat_vec(r_acc[i] + p_sh[i]);
                        if (!r_mode) begin
                            r_pos[i] <= sfcv_pkg::sat_vec(r_acc[i] + p_sh[i]);
                            r_vel[i] <= '0;
                        end
                    end
                    r_state <= r_mode ? S_SP1 : S_DIFF;
                end
                S_SP1: begin
                    for (int i = 0; i < sfcv_pkg::VEC_N; i++) begin
                        r_tmp[i] <= sfcv_pkg::sat_vec(sfcv_pkg::ext_vec(r_pos[i]) -
                                                      sfcv_pkg::ext_vec(r_ideal[i]));
                    end
                    r_state <= S_SP2;
                end
                S_SP2: r_state <= S_SP3;
                S_SP3: begin
                    for (int i = 0; i < sfcv_pkg::VEC_N; i++) begin
                        r_acc[i] <= -sfcv_pkg::ext_prod(lane_p[i]);
                    end
                    r_state <= S_SP4;
                end
                S_SP4: begin
                    for (int i = 0; i < sfcv_pkg::VEC_N; i++) begin
                        r_tmp[i] <= sfcv_pkg::sat_vec((r_acc[i] - sfcv_pkg::ext_prod(lane_p[i]))
                                                      >>> sfcv_pkg::FRAC_BITS);
                    end
                    r_state <= S_SP5;
                end
                S_SP5: r_state <= S_SP6;
                S_SP6: begin
                    for (int i = 0; i < sfcv_pkg::VEC_N; i++) begin
                        r_vel[i] <= sfcv_pkg::sat_vec(sfcv_pkg::ext_vec(r_vel[i]) + p_sh[i]);
                    end
                    r_state <= S_SP7;
                end
                S_SP7: r_state <= S_SP8;
                S_SP8: begin
                    for (int i = 0; i < sfcv_pkg::VEC_N; i++) begin
                        r_pos[i] <= sfcv_pkg::sat_vec(sfcv_pkg::ext_vec(r_pos[i]) + p_sh[i]);
                    end
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    for (int i = 0; i < sfcv_pkg::VEC_N; i++) begin
                        r_vec[i] <= sfcv_pkg::sat_vec(sfcv_pkg::ext_vec(r_tgt[i]) -
                                                      sfcv_pkg::ext_vec(r_pos[i]));
                    end
                    r_phase <= PH_F;
                    r_state <= S_N1;
                end
                S_N1: r_state <= S_N2;
                S_N2: r_state <= S_N3;
                S_N3: begin
                    if (!sqrt_busy) begin
                        r_zero  <= (root == '0);
                        r_state <= S_N4;
                    end
                end
                S_N4: begin
                    if (norm_done) begin
                        priority case (r_phase)
                            PH_F: begin
                                r_f     <= norm_q;
                                r_vec   <= r_up;
                                r_phase <= PH_UP;
                                r_state <= S_N1;
                            end
                            PH_UP: begin
                                r_ca    <= norm_q;
                                r_cb    <= r_f;
                                r_phase <= PH_LEFT;
                                r_state <= S_C1;
                            end
                            PH_LEFT: begin
                                r_ca    <= r_f;
                                r_cb    <= norm_q;
                                r_phase <= PH_CUP;
                                r_state <= S_C1;
                            end
                            PH_CUP: begin
                                r_ca    <= r_f;
                                r_cb    <= norm_q;
                                r_phase <= PH_S;
                                r_state <= S_C1;
                            end
                            default: begin
                                r_s     <= norm_q;
                                r_ca    <= norm_q;
                                r_cb    <= r_f;
                                r_phase <= PH_U;
                                r_state <= S_C1;
                            end
                        endcase
                    end
                end
                S_C1: r_state <= S_C2;
                S_C2: begin
                    for (int i = 0; i < sfcv_pkg::VEC_N; i++) begin
                        r_acc[i] <= sfcv_pkg::ext_prod(lane_p[i]);
                    end
                    r_state <= S_C3;
                end
                S_C3: begin
                    if (r_phase == PH_U) begin
                        r_u     <= cross_r;
                        r_dsel  <= DOT_S;
                        r_state <= S_D1;
                    end else begin
                        r_vec   <= cross_r;
                        r_state <= S_N1;
                    end
                end
                S_D1: r_state <= S_D2;
                S_D2: begin
                    r_dot[r_dsel] <= sfcv_pkg::sat_vec(dot_v >>> sfcv_pkg::FRAC_BITS);
                    if (r_dsel == DOT_F) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_dsel  <= r_dsel + 1'b1;
                        r_state <= S_D1;
                    end
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int i = 0; i < sfcv_pkg::VEC_N; i++) begin
                r_o_s[i]   <= r_s[i];
                r_o_u[i]   <= r_u[i];
                r_o_b[i]   <= -r_f[i];
                r_o_off[i] <= r_dot[i];
            end
        end
    end

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid         = r_out_valid;
    assign o_result.right_x       = r_o_s[0];
    assign o_result.right_y       = r_o_s[1];
    assign o_result.right_z       = r_o_s[2];
    assign o_result.right_offset  = r_o_off[0];
    assign o_result.upward_x      = r_o_u[0];
    assign o_result.upward_y      = r_o_u[1];
    assign o_result.upward_z      = r_o_u[2];
    assign o_result.upward_offset = r_o_off[1];
    assign o_result.back_x        = r_o_b[0];
    assign o_result.back_y        = r_o_b[1];
    assign o_result.back_z        = r_o_b[2];
    assign o_result.back_offset   = r_o_off[2];

    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_state == S_ID1)
        else $error("accepted item did not start the datapath");

    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_start |-> !sqrt_busy)
        else $error("square root started while busy");

    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy == '0 || div_busy == '1)
        else $error("lane dividers out of step");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !o_result.ready) |=> r_state == S_EMIT)
        else $error("result overwrote an item not yet taken");

endmodule
